/* hdl/tcrc_pkg.sv */
// Shared types and constants for the transitive closure rank counter.
// Used by tcrc_engine, transitive_closure_rank_count and the testbench.
`default_nettype none

package tcrc_pkg;

    localparam int MAX_NODES = 64;
    localparam int ADDR_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int ID_W      = 7;
    localparam int OUT_W     = 7;
    localparam int CMP_W     = ((ID_W > CNT_W) ? ID_W : CNT_W) + 1;

    typedef logic [MAX_NODES-1:0] row_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] rd_addr;
    } ram_req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE_RD,
        S_K_RD,
        S_K_LATCH,
        S_I_RD,
        S_I_WR,
        S_C_RD,
        S_C_LATCH,
        S_J_RD,
        S_J_CHK,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

/* hdl/tcrc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tcrc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hdl/tcrc_engine.sv */
// Sequencer and shared row unit: edge insert, Warshall closure, rank count.
// Depends on tcrc_pkg; drives the reachability row RAM in the top level.
`default_nettype none

module tcrc_engine
    import tcrc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [ID_W-1:0]  from_node,
    input  wire logic [ID_W-1:0]  to_node,
    input  wire logic             last_edge,
    input  wire logic [CNT_W-1:0] node_limit,
    output ram_req_t              ram_req,
    output row_t                  ram_wdata,
    input  wire row_t             ram_rdata,
    output logic                  done,
    output logic [OUT_W-1:0]      count
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  tally_reg, tally_next;
    logic              all_reg, all_next;
    row_t              valid_reg, valid_next;

    // payload registers
    row_t              hold_reg, hold_next;
    logic [ADDR_W-1:0] row_addr_reg, row_addr_next;
    logic [ADDR_W-1:0] col_reg, col_next;
    logic              last_reg, last_next;
    logic [ADDR_W-1:0] rd_addr_reg;

    logic [CMP_W-1:0]  a_ext, b_ext;
    logic              edge_ok;
    row_t              rd_row;
    logic [CNT_W-1:0]  k_inc, i_inc, j_inc;
    logic [CMP_W-1:0]  tally_ext;
    logic              pair_ok;

    assign a_ext   = CMP_W'(from_node);
    assign b_ext   = CMP_W'(to_node);
    assign edge_ok = (a_ext != '0) && (b_ext != '0) && (a_ext != b_ext)
                     && (a_ext <= CMP_W'(MAX_NODES)) && (b_ext <= CMP_W'(MAX_NODES));

    // rows never written since the last clear read as zero
    assign rd_row  = valid_reg[rd_addr_reg] ? ram_rdata : '0;

    assign k_inc   = k_reg + 1'b1;
    assign i_inc   = i_reg + 1'b1;
    assign j_inc   = j_reg + 1'b1;

    assign pair_ok = (j_reg == i_reg) || hold_reg[j_reg[ADDR_W-1:0]]
                     || rd_row[i_reg[ADDR_W-1:0]];

    assign tally_ext = CMP_W'(tally_reg);
    assign count     = (state_reg == S_DONE) ? tally_ext[OUT_W-1:0] : '0;
    assign done      = (state_reg == S_DONE);
    assign busy      = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            tally_reg <= '0;
            all_reg   <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            tally_reg <= tally_next;
            all_reg   <= all_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg     <= hold_next;
        row_addr_reg <= row_addr_next;
        col_reg      <= col_next;
        last_reg     <= last_next;
        rd_addr_reg  <= ram_req.rd_addr;
    end

    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        tally_next    = tally_reg;
        all_next      = all_reg;
        valid_next    = valid_reg;
        hold_next     = hold_reg;
        row_addr_next = row_addr_reg;
        col_next      = col_reg;
        last_next     = last_reg;
        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = row_addr_reg;
        ram_req.rd_addr = row_addr_reg;
        ram_wdata       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    row_addr_next   = ADDR_W'(a_ext - 1'b1);
                    col_next        = ADDR_W'(b_ext - 1'b1);
                    last_next       = last_edge;
                    ram_req.rd_addr = ADDR_W'(a_ext - 1'b1);
                    k_next          = '0;
                    if (edge_ok)
                    begin
                        state_next = S_EDGE_RD;
                    end
                    else if (last_edge)
                    begin
                        state_next = (node_limit == '0) ? S_DONE : S_K_RD;
                    end
                end
            end

            // read-modify-write of the source row
            S_EDGE_RD:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = row_addr_reg;
                ram_wdata       = rd_row | (row_t'(1) << col_reg);
                valid_next[row_addr_reg] = 1'b1;
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = (node_limit == '0) ? S_DONE : S_K_RD;
                end
            end

            S_K_RD:
            begin
                ram_req.rd_addr = k_reg[ADDR_W-1:0];
                state_next      = S_K_LATCH;
            end

            S_K_LATCH:
            begin
                hold_next  = rd_row;
                i_next     = '0;
                state_next = S_I_RD;
            end

            S_I_RD:
            begin
                ram_req.rd_addr = i_reg[ADDR_W-1:0];
                state_next      = S_I_WR;
            end

            // row i picks up row k when i reaches k
            S_I_WR:
            begin
                ram_req.wr_addr = i_reg[ADDR_W-1:0];
                ram_wdata       = rd_row | hold_reg;
                if (rd_row[k_reg[ADDR_W-1:0]])
                begin
                    ram_req.wr_en = 1'b1;
                    valid_next[i_reg[ADDR_W-1:0]] = 1'b1;
                end
                i_next = i_inc;
                if (i_inc == node_limit)
                begin
                    k_next = k_inc;
                    if (k_inc == node_limit)
                    begin
                        i_next     = '0;
                        tally_next = '0;
                        state_next = S_C_RD;
                    end
                    else
                    begin
                        state_next = S_K_RD;
                    end
                end
                else
                begin
                    state_next = S_I_RD;
                end
            end

            S_C_RD:
            begin
                ram_req.rd_addr = i_reg[ADDR_W-1:0];
                state_next      = S_C_LATCH;
            end

            S_C_LATCH:
            begin
                hold_next  = rd_row;
                j_next     = '0;
                all_next   = 1'b1;
                state_next = S_J_RD;
            end

            S_J_RD:
            begin
                ram_req.rd_addr = j_reg[ADDR_W-1:0];
                state_next      = S_J_CHK;
            end

            // node i against node j: i reaches j or j reaches i
            S_J_CHK:
            begin
                all_next = all_reg & pair_ok;
                j_next   = j_inc;
                if (j_inc == node_limit)
                begin
                    if (all_reg && pair_ok)
                    begin
                        tally_next = tally_reg + 1'b1;
                    end
                    i_next = i_inc;
                    state_next = (i_inc == node_limit) ? S_DONE : S_C_RD;
                end
                else
                begin
                    state_next = S_J_RD;
                end
            end

            S_DONE:
            begin
                valid_next = '0;
                tally_next = '0;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/transitive_closure_rank_count.sv */
// Top level of the transitive closure rank counter: node_count register,
// row RAM and sequencer. Depends on tcrc_pkg, tcrc_ram and tcrc_engine.
//
// Usage:
//   Requests are edges (from_node, to_node, last_edge), taken at a clock edge
//   with start high and busy low. Each edge is stored as one reachability bit
//   in a 64 x 64 row RAM by a row read and a row write.
//   Self loops and ids of 0 or above 64 are dropped.
//   The request with last_edge set also runs the Warshall closure over nodes
//   1..n and then counts nodes comparable with every other node, where n is
//   node_count saturated to 64. Closure (per pivot) and count (per node) both
//   run through the single RAM read port. The last request raises done when
//   the count is finished; busy drops in the cycle after done.
//   done is high for exactly one cycle with determined_count; the receiver
//   cannot stall it. The store is then cleared at once through per-row valid
//   bits, so the next job starts right away.
//   node_count_we writes node_count; write it only while busy is low.
//   Reset: node_count = 64, store empty, block idle.
`default_nettype none

module transitive_closure_rank_count
    import tcrc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [ID_W-1:0]  from_node,
    input  wire logic [ID_W-1:0]  to_node,
    input  wire logic             last_edge,
    input  wire logic             node_count_we,
    input  wire logic [ID_W-1:0]  node_count,
    output logic                  done,
    output logic [OUT_W-1:0]      determined_count
);

    logic [ID_W-1:0]  node_count_reg;
    logic [CMP_W-1:0] count_ext;
    logic [CMP_W-1:0] limit_ext;
    logic [CNT_W-1:0] node_limit;
    ram_req_t         ram_req;
    row_t             ram_wdata;
    row_t             ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= ID_W'(64);
        end
        else if (node_count_we)
        begin
            node_count_reg <= node_count;
        end
    end

    // n saturates at the store size
    assign count_ext  = CMP_W'(node_count_reg);
    assign limit_ext  = (count_ext > CMP_W'(MAX_NODES)) ? CMP_W'(MAX_NODES) : count_ext;
    assign node_limit = limit_ext[CNT_W-1:0];

    tcrc_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .from_node  (from_node),
        .to_node    (to_node),
        .last_edge  (last_edge),
        .node_limit (node_limit),
        .ram_req    (ram_req),
        .ram_wdata  (ram_wdata),
        .ram_rdata  (ram_rdata),
        .done       (done),
        .count      (determined_count)
    );

    tcrc_ram #(
        .WIDTH (MAX_NODES),
        .DEPTH (MAX_NODES)
    ) u_rows (
        .clk   (clk),
        .we    (ram_req.wr_en),
        .waddr (ram_req.wr_addr),
        .wdata (ram_wdata),
        .raddr (ram_req.rd_addr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

/* verif/tb_transitive_closure_rank_count.sv */
// Testbench for transitive_closure_rank_count: edge jobs are checked against a
// built-in reachability map that runs Warshall closure and the rank count.
// Depends on tcrc_pkg and the transitive_closure_rank_count RTL.
`timescale 1ns / 1ps

module tb_transitive_closure_rank_count;
    import tcrc_pkg::*;

    localparam int ITEM_TARGET = 1700;
    localparam int STALL_LIMIT = 100000;
    localparam int SETTLE      = 4;

    typedef struct packed {
        logic [ID_W-1:0] src;
        logic [ID_W-1:0] dst;
        logic            fin;
    } link_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            start = 1'b0;
    logic [ID_W-1:0] from_node = '0;
    logic [ID_W-1:0] to_node = '0;
    logic            last_edge = 1'b0;
    logic            node_count_we = 1'b0;
    logic [ID_W-1:0] node_count = '0;
    logic            busy;
    logic            done;
    logic [OUT_W-1:0] determined_count;

    // reach_map[i][j]: node i+1 reaches node j+1
    row_t             reach_map [MAX_NODES];
    logic [ID_W-1:0]  map_nodes = 7'd64;
    logic [OUT_W-1:0] pending_counts [$];
    logic [OUT_W-1:0] want_count;

    int idle_pct = 0;
    int mismatches = 0;
    int useful_requests = 0;
    int all_requests = 0;
    int jobs_closed = 0;
    int big_jobs = 0;
    int stall_cycles = 0;

    transitive_closure_rank_count dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .from_node        (from_node),
        .to_node          (to_node),
        .last_edge        (last_edge),
        .node_count_we    (node_count_we),
        .node_count       (node_count),
        .done             (done),
        .determined_count (determined_count)
    );

    always #5 clk = ~clk;

    // Stores one edge; on the last edge closes the map, counts and clears it.
    function automatic void apply_edge_to_map(input link_t r);
        int  n;
        int  tally;
        bit  all_cmp;
        if (r.src >= 1 && r.dst >= 1 && r.src <= MAX_NODES && r.dst <= MAX_NODES
            && r.src != r.dst)
            reach_map[r.src - 1][r.dst - 1] = 1'b1;
        if (!r.fin)
            return;
        n = (map_nodes > MAX_NODES) ? MAX_NODES : int'(map_nodes);
        for (int k = 0; k < n; k++)
            for (int i = 0; i < n; i++)
                if (reach_map[i][k])
                    reach_map[i] = reach_map[i] | reach_map[k];
        tally = 0;
        for (int i = 0; i < n; i++)
        begin
            all_cmp = 1'b1;
            for (int j = 0; j < n; j++)
                if (j != i && !reach_map[i][j] && !reach_map[j][i])
                    all_cmp = 1'b0;
            if (all_cmp)
                tally++;
        end
        pending_counts.push_back(tally[OUT_W-1:0]);
        for (int i = 0; i < MAX_NODES; i++)
            reach_map[i] = '0;
        jobs_closed++;
    endfunction

    task automatic send_edge(input link_t r);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        from_node <= r.src;
        to_node   <= r.dst;
        last_edge <= r.fin;
        do
            @(posedge clk);
        while (busy);
        all_requests++;
        if (r.fin || (r.src >= 1 && r.dst >= 1 && r.src <= MAX_NODES
                      && r.dst <= MAX_NODES && r.src != r.dst))
            useful_requests++;
        apply_edge_to_map(r);
    endtask

    // Only written with the block idle and every count collected.
    task automatic write_node_count(input logic [ID_W-1:0] value);
        start <= 1'b0;
        @(posedge clk);
        while (pending_counts.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        node_count_we <= 1'b1;
        node_count    <= value;
        @(posedge clk);
        node_count_we <= 1'b0;
        map_nodes = value;
    endtask

    task automatic test_reset_default;
        // node_count still 64 from reset: one edge between the outer ids
        send_edge('{7'd1, 7'd64, 1'b1});
        big_jobs++;
    endtask

    task automatic test_small_graphs;
        write_node_count(7'd1);
        send_edge('{7'd1, 7'd1, 1'b1});          // self loop, lone node still counts
        write_node_count(7'd4);
        send_edge('{7'd1, 7'd2, 1'b0});
        send_edge('{7'd2, 7'd50, 1'b0});         // above node_count: stored, unused
        send_edge('{7'd2, 7'd3, 1'b0});
        send_edge('{7'd3, 7'd4, 1'b1});
        write_node_count(7'd3);
        send_edge('{7'd1, 7'd2, 1'b0});
        send_edge('{7'd1, 7'd3, 1'b1});
        write_node_count(7'd2);
        send_edge('{7'd1, 7'd2, 1'b0});
        send_edge('{7'd2, 7'd1, 1'b1});          // cycle
    endtask

    task automatic test_dropped_ids;
        write_node_count(7'd0);
        send_edge('{7'd0, 7'd127, 1'b1});        // no nodes at all
        write_node_count(7'd3);
        send_edge('{7'd0, 7'd2, 1'b0});
        send_edge('{7'd65, 7'd2, 1'b0});
        send_edge('{7'd127, 7'd0, 1'b0});
        send_edge('{7'd2, 7'd3, 1'b0});
        send_edge('{7'd3, 7'd3, 1'b0});
        send_edge('{7'd1, 7'd2, 1'b1});
    endtask

    task automatic test_saturated_count;
        write_node_count(7'd127);
        send_edge('{7'd64, 7'd1, 1'b0});
        send_edge('{7'd63, 7'd64, 1'b1});
        big_jobs++;
        write_node_count(7'd65);
        send_edge('{7'd2, 7'd1, 1'b1});
        big_jobs++;
    endtask

    task automatic test_random_jobs;
        int    pct_table [4];
        int    ids [$];
        link_t job [$];
        int    n;
        int    m;
        int    r1;
        int    r2;
        int    tmp;
        int    kind;
        int    roll;
        int    big_left;
        pct_table = '{0, 61, 0, 18};
        big_left = 2;
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = pct_table[ph];
            while (all_requests < (ph + 1) * ITEM_TARGET / 4)
            begin
                roll = $urandom_range(0, 99);
                if (big_left > 0 && $urandom_range(0, 199) == 0)
                begin
                    n = $urandom_range(64, 127);
                    big_left--;
                    big_jobs++;
                end
                else if (roll < 3)
                    n = $urandom_range(0, 1);
                else if (roll < 80)
                    n = $urandom_range(2, 8);
                else
                    n = $urandom_range(9, 24);
                if (n != int'(map_nodes))
                    write_node_count(n[ID_W-1:0]);
                m = (n > MAX_NODES) ? MAX_NODES : n;
                kind = $urandom_range(0, 3);
                job.delete();
                ids.delete();
                for (int v = 1; v <= m; v++)
                    ids.push_back(v);
                for (int v = m - 1; v > 0; v--)
                begin
                    r1 = $urandom_range(0, v);
                    tmp = ids[v];
                    ids[v] = ids[r1];
                    ids[r1] = tmp;
                end
                if (kind <= 1 && m >= 2)
                begin
                    // random total order, mostly chained, plus forward shortcuts
                    for (int v = 0; v < m - 1; v++)
                        if ($urandom_range(0, 3) != 0)
                            job.push_back('{ids[v][ID_W-1:0], ids[v+1][ID_W-1:0], 1'b0});
                    repeat ($urandom_range(0, m / 2))
                    begin
                        r1 = $urandom_range(0, m - 2);
                        r2 = $urandom_range(r1 + 1, m - 1);
                        job.push_back('{ids[r1][ID_W-1:0], ids[r2][ID_W-1:0], 1'b0});
                    end
                end
                else if (kind == 2 && m >= 1)
                begin
                    repeat ($urandom_range(1, 2 * m + 1))
                    begin
                        r1 = $urandom_range(1, m);
                        r2 = $urandom_range(1, m);
                        job.push_back('{r1[ID_W-1:0], r2[ID_W-1:0], 1'b0});
                    end
                end
                else
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        r1 = $urandom_range(0, 127);
                        r2 = $urandom_range(0, 127);
                        job.push_back('{r1[ID_W-1:0], r2[ID_W-1:0], 1'b0});
                    end
                end
                if (job.size() == 0)
                begin
                    r1 = $urandom_range(0, 127);
                    r2 = $urandom_range(0, 127);
                    job.push_back('{r1[ID_W-1:0], r2[ID_W-1:0], 1'b0});
                end
                job[job.size() - 1].fin = 1'b1;
                foreach (job[q])
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        r1 = $urandom_range(0, 127);
                        r2 = $urandom_range(0, 127);
                        send_edge('{r1[ID_W-1:0], r2[ID_W-1:0], 1'b0});
                    end
                    send_edge(job[q]);
                end
            end
        end
        idle_pct = 0;
    endtask

    // Each done pulse must match the oldest pending count.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_counts.size() == 0)
            begin
                $display("%0t: determined_count expected none, got %0d",
                         $time, determined_count);
                mismatches++;
            end
            else
            begin
                want_count = pending_counts.pop_front();
                if (determined_count !== want_count)
                begin
                    $display("%0t: determined_count expected %0d, got %0d",
                             $time, want_count, determined_count);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no request or result for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        for (int i = 0; i < MAX_NODES; i++)
            reach_map[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_default();
        test_small_graphs();
        test_dropped_ids();
        test_saturated_count();
        test_random_jobs();
        start <= 1'b0;
        @(posedge clk);
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (pending_counts.size() != 0)
            mismatches++;
        $display("Covered %0d requests (%0d not dropped) in %0d jobs, %0d of them at 64 nodes,",
                 all_requests, useful_requests, jobs_closed, big_jobs);
        $display("node_count from 0 to 127, with sender gaps off, at 61%% and at 18%%.");
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
